// ----- rtl/core/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/ipcls_pkg.sv -----
// shared types, constants and character helpers of the address classifier
package ipcls_pkg;

    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_F  = 8'h46;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_F  = 8'h66;

    localparam logic [1:0] V4_LAST_DOT    = 2'd3;
    localparam logic [1:0] V4_MAX_DIGITS  = 2'd3;
    localparam logic [13:0] V4_MAX_VALUE  = 14'h00FF;
    localparam logic [2:0] V6_LAST_COLON  = 3'd7;
    localparam logic [2:0] V6_MAX_DIGITS  = 3'd4;

    localparam logic [1:0] CLASS_NONE = 2'd0;
    localparam logic [1:0] CLASS_V4   = 2'd1;
    localparam logic [1:0] CLASS_V6   = 2'd2;

    typedef struct packed {
        logic       alive;
        logic [1:0] dot_count;
        logic [1:0] seg_len;
        logic [9:0] seg_value;
        logic       lead_zero;
    } v4_state_t;

    typedef struct packed {
        logic       alive;
        logic [2:0] colon_count;
        logic [2:0] seg_len;
    } v6_state_t;

    localparam v4_state_t V4_RESET = '{alive: 1'b1, dot_count: 2'd0, seg_len: 2'd0,
                                       seg_value: 10'd0, lead_zero: 1'b0};
    localparam v6_state_t V6_RESET = '{alive: 1'b1, colon_count: 3'd0, seg_len: 3'd0};

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_dec(c) || ((c >= CHAR_UP_A) && (c <= CHAR_UP_F))
            || ((c >= CHAR_LO_A) && (c <= CHAR_LO_F));
    endfunction

endpackage

// ----- rtl/core/ip_address_text_classifier.sv -----
// top level of the ipv4 / ipv6 address text classifier
//
// usage
// - input channel s_*: one character per transfer (s_char_code), with
//   s_last_char set on the final character of each address string
// - result channel m_*: one transfer per string, m_address_class is
//   0 neither, 1 dotted ipv4, 2 colon ipv6; other characters give no result
// - throughput: one character per cycle, sustained, as long as results
//   are taken; the ipv4 and ipv6 recognizers share one input register and
//   update their state when the character held in it advances
// - result path: a final character goes from the input register through
//   the recognizers into the output register, which drives m_valid
// - stall: a result waiting in the output register does not block further
//   characters of the next string; only a final character waits in the
//   input register until the output register is free, and then s_ready drops
// - reset (aresetn low, synchronous): both recognizers return to their
//   start state and both register stages are emptied
// - after every final character the recognizers restart for the next string
module ip_address_text_classifier
    import ipcls_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_code,
    input  logic       s_last_char,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_address_class
);

    // input register
    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       in_last_reg;

    // recognizer state
    v4_state_t v4_reg, v4_next, v4_upd;
    v6_state_t v6_reg, v6_next, v6_upd;
    logic      v4_ok, v6_ok;

    // result register
    logic       m_valid_reg;
    logic [1:0] class_reg;
    logic [1:0] class_next;

    logic advance;
    logic s_xfer;
    logic m_xfer;

    // a character without a result always moves on; a final one needs a free slot
    assign advance = in_valid_reg && (!in_last_reg || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_xfer  = s_valid && s_ready;
    assign m_xfer  = m_valid_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_char_reg <= s_char_code;
            in_last_reg <= s_last_char;
        end
    end

    ipcls_v4_rec u_v4 (
        .cur       (v4_reg),
        .char_code (in_char_reg),
        .nxt       (v4_upd),
        .complete  (v4_ok)
    );

    ipcls_v6_rec u_v6 (
        .cur       (v6_reg),
        .char_code (in_char_reg),
        .nxt       (v6_upd),
        .complete  (v6_ok)
    );

    // restart both recognizers after the final character
    assign v4_next = in_last_reg ? V4_RESET : v4_upd;
    assign v6_next = in_last_reg ? V6_RESET : v6_upd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= V4_RESET;
            v6_reg <= V6_RESET;
        end else if (advance) begin
            v4_reg <= v4_next;
            v6_reg <= v6_next;
        end
    end

    // ipv4 wins when both would match (cannot happen, the separators differ)
    always_comb begin
        if (v4_ok) begin
            class_next = CLASS_V4;
        end else if (v6_ok) begin
            class_next = CLASS_V6;
        end else begin
            class_next = CLASS_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_xfer) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            class_reg <= class_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_address_class = class_reg;

endmodule

// ----- rtl/core/ipcls_v4_rec.sv -----
// dotted ipv4 recognizer: next state for one character
module ipcls_v4_rec
    import ipcls_pkg::*;
(
    input  v4_state_t  cur,
    input  logic [7:0] char_code,
    output v4_state_t  nxt,
    output logic       complete
);

    logic [3:0]  digit;
    logic [13:0] grown;

    assign digit = char_code[3:0];
    assign grown = {4'd0, cur.seg_value} * 14'd10 + {10'd0, digit};

    always_comb begin
        nxt = cur;
        if (cur.alive) begin
            if (char_code == CHAR_DOT) begin
                if ((cur.seg_len == 2'd0) || (cur.dot_count == V4_LAST_DOT)) begin
                    nxt.alive = 1'b0;
                end else begin
                    nxt.dot_count = cur.dot_count + 2'd1;
                    nxt.seg_len   = 2'd0;
                    nxt.seg_value = 10'd0;
                    nxt.lead_zero = 1'b0;
                end
            end else if (is_dec(char_code)) begin
                if (cur.seg_len == 2'd0) begin
                    nxt.seg_value = {6'd0, digit};
                    nxt.lead_zero = (digit == 4'd0);
                    nxt.seg_len   = 2'd1;
                end else if (cur.lead_zero || (cur.seg_len == V4_MAX_DIGITS)
                             || (grown > V4_MAX_VALUE)) begin
                    nxt.alive = 1'b0;
                end else begin
                    nxt.seg_value = grown[9:0];
                    nxt.seg_len   = cur.seg_len + 2'd1;
                end
            end else begin
                nxt.alive = 1'b0;
            end
        end
    end

    assign complete = nxt.alive && (nxt.dot_count == V4_LAST_DOT) && (nxt.seg_len != 2'd0);

endmodule

// ----- rtl/core/ipcls_v6_rec.sv -----
// colon ipv6 recognizer: next state for one character
module ipcls_v6_rec
    import ipcls_pkg::*;
(
    input  v6_state_t  cur,
    input  logic [7:0] char_code,
    output v6_state_t  nxt,
    output logic       complete
);

    always_comb begin
        nxt = cur;
        if (cur.alive) begin
            if (char_code == CHAR_COLON) begin
                if ((cur.seg_len == 3'd0) || (cur.colon_count == V6_LAST_COLON)) begin
                    nxt.alive = 1'b0;
                end else begin
                    nxt.colon_count = cur.colon_count + 3'd1;
                    nxt.seg_len     = 3'd0;
                end
            end else if (is_hex(char_code)) begin
                if (cur.seg_len >= V6_MAX_DIGITS) begin
                    nxt.alive = 1'b0;
                end else begin
                    nxt.seg_len = cur.seg_len + 3'd1;
                end
            end else begin
                nxt.alive = 1'b0;
            end
        end
    end

    assign complete = nxt.alive && (nxt.colon_count == V6_LAST_COLON)
        && (nxt.seg_len != 3'd0);

endmodule

// ----- rtl/core/ipcls_checker.sv -----
// port-level checker of the address classifier and its bind
`include "assert_macros.svh"

module ipcls_checker
    import ipcls_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       s_last_char,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_address_class
);

    logic result_stalled;
    logic class_known;
    logic last_xfer;

    assign result_stalled = m_valid && !m_ready;
    assign class_known    = (m_address_class == CLASS_NONE) || (m_address_class == CLASS_V4)
                         || (m_address_class == CLASS_V6);
    assign last_xfer      = s_valid && s_ready && s_last_char;

    // a stalled result holds
    `ASSERT_NEXT(a_result_holds, aclk, aresetn, result_stalled, m_valid && $stable(m_address_class))

    // only the three defined class codes appear
    `ASSERT_IMPLY(a_class_code, aclk, aresetn, m_valid, class_known)

    // input backpressure only while a result waits unaccepted
    `ASSERT_IMPLY(a_ready_low_only_on_stall, aclk, aresetn, !s_ready, result_stalled)

    // a new result must trace back to an earlier final character transfer
    `ASSERT_IMPLY(a_result_source, aclk, aresetn, $rose(m_valid), $past(last_xfer, 2))

endmodule

bind ip_address_text_classifier ipcls_checker u_ipcls_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .s_last_char     (s_last_char),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_address_class (m_address_class)
);
